// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Assertion failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Assertion failed one cycle later.");

`endif

// ===== hw/rtl/b2d128_pkg.sv =====
package b2d128_pkg;

    localparam int VALUE_BITS  = 128;
    localparam int DIGIT_COUNT = 39;
    localparam int HALF_BITS   = 64;
    localparam int IN_BITS     = 2 * HALF_BITS;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGIT_COUNT * DIGIT_W;
    localparam int STEP_W      = $clog2(VALUE_BITS);
    localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
    localparam int OUT_DATA_W  = 8;

    typedef struct packed {
        logic load;
        logic dabble;
        logic advance;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic last_digit;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/binary_to_decimal_128.sv =====
// Operation: a value is loaded and converted by shift-and-add-3 steps, then its
// digits are emitted from the most significant down; each digit position takes its
// own emit step whether it is skipped as a leading zero or sent through the output
// register. A new value is taken only when idle, after the last digit is pushed.
// Reset: i_rst_n is synchronous and active low; it idles the controller and
// empties the output register.
module binary_to_decimal_128 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0 up: value_high[63:0], value_low[63:0].
    input  logic [b2d128_pkg::IN_BITS-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0 up: digit[3:0], zero fill[7:4].
    output logic [b2d128_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast
);

    b2d128_pkg::t_cmd               w_cmd;
    b2d128_pkg::t_stat              w_stat;
    logic [b2d128_pkg::IN_BITS-1:0] w_value;
    logic [b2d128_pkg::DIGIT_W-1:0] w_digit;

    assign w_value = {s_axis_tdata[b2d128_pkg::HALF_BITS-1:0],
                      s_axis_tdata[b2d128_pkg::IN_BITS-1:b2d128_pkg::HALF_BITS]};

    b2d128_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    b2d128_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (w_value),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_digit     (w_digit),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(b2d128_pkg::OUT_DATA_W - b2d128_pkg::DIGIT_W){1'b0}}, w_digit};

endmodule

// ===== hw/rtl/b2d128_ctrl.sv =====
module b2d128_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  b2d128_pkg::t_stat i_stat,
    output b2d128_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_lead;
    logic   w_skip;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_skip     = r_lead && i_stat.top_zero && !i_stat.last_digit;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
            end
            S_EMIT: begin
                priority if (w_skip) begin
                    o_cmd.advance = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.advance = 1'b1;
                    o_cmd.push    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lead  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (i_stat.conv_done) begin
                        r_state <= S_EMIT;
                        r_lead  <= 1'b1;
                    end
                end
                S_EMIT: begin
                    priority if (w_skip) begin
                        r_lead <= 1'b1;
                    end else if (i_stat.out_free) begin
                        r_lead <= 1'b0;
                        if (i_stat.last_digit) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/b2d128_dp.sv =====
module b2d128_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  b2d128_pkg::t_cmd                   i_cmd,
    output b2d128_pkg::t_stat                  o_stat,
    input  logic [b2d128_pkg::IN_BITS-1:0]     i_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [b2d128_pkg::DIGIT_W-1:0]     o_digit,
    output logic                               o_last
);

    logic [b2d128_pkg::VALUE_BITS-1:0] r_shift;
    logic [b2d128_pkg::BCD_W-1:0]      r_bcd;
    logic [b2d128_pkg::BCD_W-1:0]      n_bcd;
    logic [b2d128_pkg::STEP_W-1:0]     r_step;
    logic [b2d128_pkg::CNT_W-1:0]      r_cnt;
    logic                              r_out_valid;
    logic [b2d128_pkg::DIGIT_W-1:0]    r_digit;
    logic                              r_last;
    logic [b2d128_pkg::DIGIT_W-1:0]    w_top;
    logic [b2d128_pkg::DIGIT_COUNT:0]  w_carry;

    assign w_top = r_bcd[b2d128_pkg::BCD_W-1 -: b2d128_pkg::DIGIT_W];

    // Each digit is corrected on its own, so the carries do not ripple.
    always_comb begin
        logic [b2d128_pkg::DIGIT_W-1:0] v;
        w_carry[0] = r_shift[b2d128_pkg::VALUE_BITS-1];
        for (int d = 0; d < b2d128_pkg::DIGIT_COUNT; d++) begin
            v = r_bcd[d*b2d128_pkg::DIGIT_W +: b2d128_pkg::DIGIT_W];
            if (v >= 4'd5) begin
                v = v + 4'd3;
            end
            n_bcd[d*b2d128_pkg::DIGIT_W +: b2d128_pkg::DIGIT_W] =
                {v[b2d128_pkg::DIGIT_W-2:0], w_carry[d]};
            w_carry[d+1] = v[b2d128_pkg::DIGIT_W-1];
        end
    end

    assign o_stat.conv_done  = (r_step == b2d128_pkg::STEP_W'(b2d128_pkg::VALUE_BITS - 1));
    assign o_stat.top_zero   = (w_top == '0);
    assign o_stat.last_digit = (r_cnt == b2d128_pkg::CNT_W'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= i_value[b2d128_pkg::VALUE_BITS-1:0];
            r_bcd   <= '0;
            r_step  <= '0;
            r_cnt   <= b2d128_pkg::CNT_W'(b2d128_pkg::DIGIT_COUNT);
        end else if (i_cmd.dabble) begin
            r_shift <= {r_shift[b2d128_pkg::VALUE_BITS-2:0], 1'b0};
            r_bcd   <= n_bcd;
            r_step  <= r_step + b2d128_pkg::STEP_W'(1);
        end else if (i_cmd.advance) begin
            r_bcd   <= {r_bcd[b2d128_pkg::BCD_W-b2d128_pkg::DIGIT_W-1:0],
                        {b2d128_pkg::DIGIT_W{1'b0}}};
            r_cnt   <= r_cnt - b2d128_pkg::CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_digit <= w_top;
            r_last  <= o_stat.last_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_last      = r_last;

endmodule

// ===== hw/rtl/b2d128_chk.sv =====
`include "assert_macros.svh"

module b2d128_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [b2d128_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);

    logic                            r_first;
    logic                            w_in_acc;
    logic                            w_out_acc;
    logic                            w_out_stall;
    logic                            w_lead;
    logic [b2d128_pkg::OUT_DATA_W:0] w_out_word;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_acc   = m_axis_tvalid && m_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_lead      = m_axis_tvalid && r_first && !m_axis_tlast;
    assign w_out_word  = {m_axis_tlast, m_axis_tdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_out_acc) begin
            r_first <= m_axis_tlast;
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(w_out_word))
    `ASSERT_SAME(a_digit_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata <= 8'd9)
    `ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    `ASSERT_SAME(a_no_lead_zero, i_clk, i_rst_n, w_lead, m_axis_tdata != 8'd0)

endmodule

bind binary_to_decimal_128 b2d128_chk u_b2d128_chk (.*);

// ===== tb/binary_to_decimal_128_test.sv =====
`timescale 1ns / 1ps

module binary_to_decimal_128_test;

    localparam int RANDOM_VALUES = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int REPORT_LIMIT  = 10;

    // The first field sits in the lowest bits of a packed struct's last member.
    typedef struct packed {
        logic [b2d128_pkg::HALF_BITS-1:0] value_low;
        logic [b2d128_pkg::HALF_BITS-1:0] value_high;
    } t_value_req;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [b2d128_pkg::IN_BITS-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [b2d128_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                                m_axis_tlast;

    t_value_req                     pending_values[$];
    logic [b2d128_pkg::DIGIT_W-1:0] digit_queue[$];
    logic                           last_queue[$];

    int values_accepted = 0;
    int mismatches      = 0;
    int cycle_count     = 0;
    int send_gap        = 0;
    int recv_stall      = 0;
    int recv_draw;
    bit send_burst      = 1'b0;
    bit recv_burst      = 1'b0;
    logic [b2d128_pkg::DIGIT_W-1:0] want_digit;
    logic                           want_last;

    binary_to_decimal_128 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic queue_value(input logic [b2d128_pkg::IN_BITS-1:0] value);
        t_value_req req;
        req.value_high = value[b2d128_pkg::IN_BITS-1:b2d128_pkg::HALF_BITS];
        req.value_low  = value[b2d128_pkg::HALF_BITS-1:0];
        pending_values = {pending_values, req};
    endtask

    task automatic predict_digits(input t_value_req req);
        logic [b2d128_pkg::IN_BITS-1:0] rest;
        logic [b2d128_pkg::DIGIT_W-1:0] digits[b2d128_pkg::DIGIT_COUNT];
        int                             top;
        rest = {req.value_high, req.value_low};
        top  = 0;
        for (int i = 0; i < b2d128_pkg::DIGIT_COUNT; i++) begin
            digits[i] = b2d128_pkg::DIGIT_W'(rest % 10);
            rest      = rest / 10;
            if (digits[i] != 0) begin
                top = i;
            end
        end
        for (int i = top; i >= 0; i--) begin
            digit_queue = {digit_queue, digits[i]};
            last_queue  = {last_queue, (i == 0)};
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_digits(t_value_req'(s_axis_tdata));
                values_accepted <= values_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_values.size() > 0) begin
                    s_axis_tdata  <= pending_values.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0) begin
                        send_burst <= !send_burst;
                    end
                    send_gap <= send_burst ? 0 : $urandom_range(0, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (digit_queue.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("Unexpected digit: tdata %0h tlast %0b", m_axis_tdata,
                             m_axis_tlast);
                end
                mismatches++;
            end else begin
                want_digit = digit_queue.pop_front();
                want_last  = last_queue.pop_front();
                if (m_axis_tdata !== b2d128_pkg::OUT_DATA_W'(want_digit) ||
                    m_axis_tlast !== want_last) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("Digit mismatch: expected %0d last %0b, got tdata %0h last %0b",
                                 want_digit, want_last, m_axis_tdata, m_axis_tlast);
                    end
                    mismatches++;
                end
            end
            if ($urandom_range(0, 15) == 0) begin
                recv_burst <= !recv_burst;
            end
            recv_draw = recv_burst ? 0 : $urandom_range(0, 7);
            recv_stall    <= recv_draw;
            m_axis_tready <= (recv_draw == 0);
        end else if (!m_axis_tready) begin
            if (recv_stall <= 1) begin
                recv_stall    <= 0;
                m_axis_tready <= 1'b1;
            end else begin
                recv_stall <= recv_stall - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [b2d128_pkg::IN_BITS-1:0] value;
        logic [b2d128_pkg::IN_BITS-1:0] power;
        int                             total;
        int                             shape;

        // Edges of the range, the half boundary and powers of ten on both sides.
        queue_value('0);
        queue_value(b2d128_pkg::IN_BITS'(1));
        queue_value('1);
        queue_value({{b2d128_pkg::HALF_BITS{1'b0}}, {b2d128_pkg::HALF_BITS{1'b1}}});
        queue_value({{(b2d128_pkg::HALF_BITS - 1){1'b0}}, 1'b1,
                     {b2d128_pkg::HALF_BITS{1'b0}}});
        queue_value({{b2d128_pkg::HALF_BITS{1'b1}}, {b2d128_pkg::HALF_BITS{1'b0}}});
        queue_value({1'b1, {(b2d128_pkg::IN_BITS - 1){1'b0}}});
        queue_value({(b2d128_pkg::IN_BITS / 2){2'b10}});
        queue_value({(b2d128_pkg::IN_BITS / 2){2'b01}});
        power = b2d128_pkg::IN_BITS'(1);
        for (int k = 1; k <= 38; k++) begin
            power = power * 10;
            if (k == 1 || k == 2 || k == 19 || k == 20 || k == 38) begin
                queue_value(power - 1);
                queue_value(power);
            end
        end

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            value = {$urandom, $urandom, $urandom, $urandom};
            shape = $urandom_range(0, 3);
            if (shape == 1) begin
                value = value >> $urandom_range(0, b2d128_pkg::IN_BITS - 1);
            end else if (shape == 2) begin
                value = b2d128_pkg::IN_BITS'($urandom_range(0, 999));
            end else if (shape == 3) begin
                value[b2d128_pkg::IN_BITS-1:b2d128_pkg::HALF_BITS] = '0;
            end
            queue_value(value);
        end
        total = pending_values.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (values_accepted < total || digit_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && digit_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/b2d128_pkg.sv
hw/rtl/b2d128_ctrl.sv
hw/rtl/b2d128_dp.sv
hw/rtl/binary_to_decimal_128.sv
hw/rtl/b2d128_chk.sv
tb/binary_to_decimal_128_test.sv
